// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int CAPACITY     = 16;
  localparam int PAYLOAD_BITS = 32;

  localparam int PRIO_W  = 16;
  localparam int TAG_W   = 32;
  localparam int POS_W   = 8;
  localparam int COUNT_W = 9;
  localparam int CNT_W   = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [PAYLOAD_BITS-1:0]  data;
  } entry_t;

  // per-cell control from the top level
  typedef struct packed {
    logic occupied;
    logic push_en;
    logic pull_en;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: keeps, takes the new entry, takes the left
// neighbour on insert, or takes the right neighbour on removal.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire                  clk,
  input  spq_pkg::cell_ctrl_t  ctrl,
  input  spq_pkg::entry_t      new_entry,
  input  wire                  left_after,
  input  spq_pkg::entry_t      left_entry,
  input  spq_pkg::entry_t      right_entry,
  output logic                 after_o,
  output spq_pkg::entry_t      entry_o,
  output spq_pkg::entry_t      entry_nxt_o
);
  import spq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // set when the new entry belongs at or before this slot
  assign after_o = !ctrl.occupied || (entry_r.prio > new_entry.prio);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.push_en && after_o) begin
      entry_nxt = left_after ? left_entry : new_entry;
    end else if (ctrl.pull_en) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o     = entry_r;
  assign entry_nxt_o = entry_nxt;

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held as a sorted chain of cells, head at slot 0.
// ----------------------------------------------------------------------------
// One operation is accepted per clock whenever the output register frees the
// input side (the result beat is taken or none is pending); its result beat
// appears on the next cycle. Every cell compares its priority with the pushed
// one and moves in the same cycle, so the rate is set by one signed compare
// per cell plus the insert/shift select. Ties are served in push order.
`default_nettype none

module sorted_priority_queue (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [1:0]                    in_operation,
  input  wire  signed [15:0]            in_priority_req,
  input  wire  [31:0]                   in_payload,
  input  wire  [7:0]                    in_position,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [1:0]                    out_status,
  output logic                          out_head_valid,
  output logic signed [15:0]            out_head_priority,
  output logic [31:0]                   out_head_payload,
  output logic [8:0]                    out_entry_count
);
  import spq_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  status_t          status_r, status_nxt;
  logic             head_valid_r;
  entry_t           head_r, head_nxt;

  logic    accept;
  op_t     op;
  logic    is_full, is_empty, pos_ok;
  logic    push_ok, pull_ok;
  entry_t  new_entry;

  cell_ctrl_t ctrl   [CAPACITY];
  logic       after  [CAPACITY];
  entry_t     cur    [CAPACITY];
  entry_t     nxt    [CAPACITY];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign op       = op_t'(in_operation);

  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign pos_ok   = ({{COUNT_W-POS_W{1'b0}}, in_position} < COUNT_W'(count_r));

  assign new_entry.prio = in_priority_req;
  assign new_entry.data = in_payload[PAYLOAD_BITS-1:0];

  assign push_ok = accept && (op == OP_PUSH) && !is_full;
  assign pull_ok = accept && !is_empty &&
                   ((op == OP_POP) || ((op == OP_REMOVE) && pos_ok));

  always_comb begin
    status_nxt = ST_OK;
    count_nxt  = count_r;
    unique case (op)
      OP_PUSH: begin
        if (is_full) status_nxt = ST_FULL;
        else         count_nxt  = count_r + CNT_W'(1);
      end
      OP_POP: begin
        if (is_empty) status_nxt = ST_EMPTY;
        else          count_nxt  = count_r - CNT_W'(1);
      end
      OP_REMOVE: begin
        if (is_empty)    status_nxt = ST_EMPTY;
        else if (!pos_ok) status_nxt = ST_RANGE;
        else             count_nxt  = count_r - CNT_W'(1);
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // removal point: pop always shifts from slot 0
  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      assign ctrl[i].occupied = (CNT_W'(i) < count_r);
      assign ctrl[i].push_en  = push_ok;
      assign ctrl[i].pull_en  = pull_ok &&
        ((op == OP_POP) || (COUNT_W'(i) >= {{COUNT_W-POS_W{1'b0}}, in_position}));

      spq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl[i]),
        .new_entry   (new_entry),
        .left_after  ((i == 0) ? 1'b0 : after[(i == 0) ? 0 : i-1]),
        .left_entry  (cur[(i == 0) ? 0 : i-1]),
        .right_entry (cur[(i == CAPACITY-1) ? i : i+1]),
        .after_o     (after[i]),
        .entry_o     (cur[i]),
        .entry_nxt_o (nxt[i])
      );
    end
  endgenerate

  assign head_nxt = nxt[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r     <= status_nxt;
      head_valid_r <= (count_nxt != '0);
      head_r       <= head_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_head_valid    = head_valid_r;
  assign out_head_priority = head_valid_r ? head_r.prio : '0;
  assign out_head_payload  = head_valid_r ? TAG_W'(head_r.data) : '0;
  assign out_entry_count   = COUNT_W'(count_r);

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (op == OP_PUSH) && is_full |=> (out_status == ST_FULL) && $stable(count_r))
    else $error("push on full store not rejected");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (op == OP_CLEAR) |=> out_valid && (out_entry_count == '0) && !out_head_valid)
    else $error("clear did not empty the store");

  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_head_valid == (out_entry_count != '0)))
    else $error("head valid disagrees with entry count");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted priority queue: a directed table of
// corner operations, then about a thousand random operations, scored against
// the bench's sorted shadow store or, for typed rows, the table's results.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import spq_pkg::*;

  typedef struct {
    status_t            status;
    logic               head_valid;
    logic signed [15:0] head_prio;
    logic [31:0]        head_data;
    logic [8:0]         count;
  } head_report_t;

  typedef struct {
    op_t                op;
    logic signed [15:0] prio;
    logic [31:0]        data;
    logic [7:0]         pos;
    bit                 typed;
    head_report_t       want;
  } dir_row_t;

  localparam int RANDOM_ITEMS = 1100;
  localparam int BLOCK_LEN    = 40;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_operation;
  logic signed [15:0] in_priority_req;
  logic [31:0]        in_payload;
  logic [7:0]         in_position;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_status;
  logic               out_head_valid;
  logic signed [15:0] out_head_priority;
  logic [31:0]        out_head_payload;
  logic [8:0]         out_entry_count;

  // shadow copy of the sorted store
  entry_t       shadow_entries [CAPACITY];
  int           shadow_count;
  head_report_t pending_reports [$];
  dir_row_t     dir_rows [$];

  int  mismatches;
  int  reports_seen;
  int  ops_sent [4];
  int  status_seen [4];
  int  peak_count;
  bit  no_idle;

  sorted_priority_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_priority_req  (in_priority_req),
    .in_payload       (in_payload),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_head_valid   (out_head_valid),
    .out_head_priority(out_head_priority),
    .out_head_payload (out_head_payload),
    .out_entry_count  (out_entry_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void drop_at(int pos);
    for (int k = pos; k + 1 < shadow_count; k++) begin
      shadow_entries[k] = shadow_entries[k+1];
    end
    shadow_count--;
  endfunction

  // applies one operation to the shadow store and returns the result beat
  function automatic head_report_t apply_op(op_t op, logic signed [15:0] prio,
                                            logic [31:0] data, logic [7:0] pos);
    head_report_t rpt;
    int slot;
    rpt.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (shadow_count >= CAPACITY) begin
          rpt.status = ST_FULL;
        end else begin
          slot = 0;
          // ties go behind, so equal priorities leave in push order
          while (slot < shadow_count &&
                 $signed(shadow_entries[slot].prio) <= $signed(prio)) slot++;
          for (int k = shadow_count; k > slot; k--) begin
            shadow_entries[k] = shadow_entries[k-1];
          end
          shadow_entries[slot].prio = prio;
          shadow_entries[slot].data = data[PAYLOAD_BITS-1:0];
          shadow_count++;
        end
      end
      OP_POP: begin
        if (shadow_count == 0) rpt.status = ST_EMPTY;
        else drop_at(0);
      end
      OP_REMOVE: begin
        if (shadow_count == 0) rpt.status = ST_EMPTY;
        else if (int'(pos) >= shadow_count) rpt.status = ST_RANGE;
        else drop_at(int'(pos));
      end
      default: begin
        shadow_count = 0;
      end
    endcase
    rpt.head_valid = (shadow_count > 0);
    rpt.head_prio  = rpt.head_valid ? shadow_entries[0].prio : 16'sd0;
    rpt.head_data  = rpt.head_valid ? 32'(shadow_entries[0].data) : 32'd0;
    rpt.count      = 9'(shadow_count);
    return rpt;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_row(op_t op, logic signed [15:0] prio, logic [31:0] data,
                         logic [7:0] pos, bit typed, status_t st, logic hv,
                         logic signed [15:0] hp, logic [31:0] hd, logic [8:0] cnt);
    dir_row_t row;
    row.op              = op;
    row.prio            = prio;
    row.data            = data;
    row.pos             = pos;
    row.typed           = typed;
    row.want.status     = st;
    row.want.head_valid = hv;
    row.want.head_prio  = hp;
    row.want.head_data  = hd;
    row.want.count      = cnt;
    dir_rows.push_back(row);
  endtask

  // called at a falling edge; returns at a falling edge after the beat and its gap
  task automatic issue_op(op_t op, logic signed [15:0] prio, logic [31:0] data,
                          logic [7:0] pos, bit typed, head_report_t want);
    head_report_t predicted;
    int gap;
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_priority_req <= prio;
    in_payload      <= data;
    in_position     <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_op(op, prio, data, pos);
    pending_reports.push_back(typed ? want : predicted);
    ops_sent[op]++;
    if (shadow_count > peak_count) peak_count = shadow_count;
    @(negedge clk);
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // result side: one beat per handshake, scored against the oldest expectation
  always @(posedge clk) begin
    head_report_t exp_rpt;
    if (rst_n && out_valid && out_ready) begin
      reports_seen++;
      status_seen[out_status]++;
      if (pending_reports.size() == 0) begin
        $display("%0t: result beat with nothing expected (status %0d count %0d)",
                 $time, out_status, out_entry_count);
        mismatches++;
      end else begin
        exp_rpt = pending_reports.pop_front();
        if (out_status !== exp_rpt.status) begin
          $display("%0t: status expected %0d got %0d", $time, exp_rpt.status, out_status);
          mismatches++;
        end
        if (out_head_valid !== exp_rpt.head_valid) begin
          $display("%0t: head_valid expected %0b got %0b", $time,
                   exp_rpt.head_valid, out_head_valid);
          mismatches++;
        end
        if (out_head_priority !== exp_rpt.head_prio) begin
          $display("%0t: head_priority expected %0d got %0d", $time,
                   exp_rpt.head_prio, out_head_priority);
          mismatches++;
        end
        if (out_head_payload !== exp_rpt.head_data) begin
          $display("%0t: head_payload expected %h got %h", $time,
                   exp_rpt.head_data, out_head_payload);
          mismatches++;
        end
        if (out_entry_count !== exp_rpt.count) begin
          $display("%0t: entry_count expected %0d got %0d", $time,
                   exp_rpt.count, out_entry_count);
          mismatches++;
        end
      end
    end
  end

  // result-side stalls
  initial begin : ready_gen
    int n;
    @(negedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      n = idle_len();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  end

  initial begin : watchdog
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    head_report_t none_rpt;
    op_t op;
    logic signed [15:0] prio;
    logic [31:0] data;
    int pos;
    int mode;
    int r;

    in_valid        = 1'b0;
    in_operation    = OP_PUSH;
    in_priority_req = 16'sd0;
    in_payload      = 32'd0;
    in_position     = 8'd0;
    out_ready       = 1'b0;
    rst_n           = 1'b0;
    shadow_count    = 0;
    mismatches      = 0;
    reports_seen    = 0;
    peak_count      = 0;
    no_idle         = 1'b0;
    for (int k = 0; k < 4; k++) begin
      ops_sent[k]    = 0;
      status_seen[k] = 0;
    end
    none_rpt = '{ST_OK, 1'b0, 16'sd0, 32'd0, 9'd0};

    // empty store first, then fill with extremes and ties, then overfill and drain
    add_row(OP_POP,    16'sd0, 32'h0, 8'd0,   1, ST_EMPTY, 0, 16'sd0, 32'h0, 9'd0);
    add_row(OP_REMOVE, 16'sd0, 32'h0, 8'd0,   1, ST_EMPTY, 0, 16'sd0, 32'h0, 9'd0);
    add_row(OP_REMOVE, 16'sd0, 32'h0, 8'd255, 1, ST_EMPTY, 0, 16'sd0, 32'h0, 9'd0);
    add_row(OP_CLEAR,  16'sd0, 32'h0, 8'd0,   1, ST_OK,    0, 16'sd0, 32'h0, 9'd0);
    add_row(OP_PUSH, 16'sd0, 32'h0000_0000, 8'd0, 1, ST_OK, 1, 16'sd0, 32'h0, 9'd1);
    add_row(OP_PUSH, 16'sh7fff, 32'hffff_ffff, 8'd0, 1, ST_OK, 1, 16'sd0, 32'h0, 9'd2);
    add_row(OP_PUSH, -16'sd32768, 32'ha5a5_a5a5, 8'd0, 1, ST_OK, 1, -16'sd32768,
            32'ha5a5_a5a5, 9'd3);
    add_row(OP_PUSH, 16'sd0,      32'h5a5a_5a5a, 8'd0,  0, ST_OK, 0, 0, 0, 0);
    add_row(OP_PUSH, -16'sd1,     32'h0000_0011, 8'd0,  0, ST_OK, 0, 0, 0, 0);
    add_row(OP_PUSH, 16'sd1,      32'h0000_0012, 8'd0,  0, ST_OK, 0, 0, 0, 0);
    add_row(OP_PUSH, -16'sd32768, 32'h0000_0001, 8'd0,  0, ST_OK, 0, 0, 0, 0);
    add_row(OP_PUSH, 16'sh7fff,   32'h0000_0002, 8'd0,  0, ST_OK, 0, 0, 0, 0);
    add_row(OP_PUSH, 16'sd100,    32'hdead_0100, 8'd0,  0, ST_OK, 0, 0, 0, 0);
    add_row(OP_PUSH, -16'sd100,   32'hdead_ff9c, 8'd0,  0, ST_OK, 0, 0, 0, 0);
    add_row(OP_PUSH, 16'sd0,      32'h0000_0013, 8'd0,  0, ST_OK, 0, 0, 0, 0);
    add_row(OP_PUSH, 16'sd256,    32'h1234_5678, 8'd0,  0, ST_OK, 0, 0, 0, 0);
    add_row(OP_PUSH, -16'sd256,   32'h8765_4321, 8'd0,  0, ST_OK, 0, 0, 0, 0);
    add_row(OP_PUSH, 16'sd5,      32'h0000_0505, 8'd0,  0, ST_OK, 0, 0, 0, 0);
    add_row(OP_PUSH, 16'sd5,      32'h0000_0506, 8'd0,  0, ST_OK, 0, 0, 0, 0);
    add_row(OP_PUSH, 16'sd5,      32'h0000_0507, 8'd0,  0, ST_OK, 0, 0, 0, 0);
    add_row(OP_PUSH, 16'sh7fff, 32'hcafe_cafe, 8'd0, 1, ST_FULL, 1, -16'sd32768,
            32'ha5a5_a5a5, 9'd16);
    add_row(OP_REMOVE, 16'sd0, 32'h0, 8'd255, 1, ST_RANGE, 1, -16'sd32768,
            32'ha5a5_a5a5, 9'd16);
    add_row(OP_REMOVE, 16'sd0, 32'h0, 8'd16, 1, ST_RANGE, 1, -16'sd32768,
            32'ha5a5_a5a5, 9'd16);
    add_row(OP_REMOVE, 16'sd0, 32'h0, 8'd15, 0, ST_OK, 0, 0, 0, 0);
    add_row(OP_REMOVE, 16'sd0, 32'h0, 8'd0,  0, ST_OK, 0, 0, 0, 0);
    add_row(OP_POP,    16'sd0, 32'h0, 8'd0,  0, ST_OK, 0, 0, 0, 0);
    add_row(OP_CLEAR,  16'sd0, 32'h0, 8'd0,  1, ST_OK, 0, 16'sd0, 32'h0, 9'd0);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      issue_op(dir_rows[i].op, dir_rows[i].prio, dir_rows[i].data, dir_rows[i].pos,
               dir_rows[i].typed, dir_rows[i].want);
    end

    mode = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % BLOCK_LEN == 0) begin
        mode    = $urandom_range(0, 3);
        no_idle = ($urandom_range(0, 4) == 0);
        // every fifth block the sender holds off until all expected result beats are in
        if ((n / BLOCK_LEN) % 5 == 2) begin
          in_valid <= 1'b0;
          while (pending_reports.size() != 0) @(negedge clk);
        end
      end
      r = $urandom_range(0, 99);
      case (mode)
        0:       op = (r < 78) ? OP_PUSH : (r < 88) ? OP_POP : OP_REMOVE;
        1:       op = (r < 20) ? OP_PUSH : (r < 55) ? OP_POP :
                      (r < 97) ? OP_REMOVE : OP_CLEAR;
        default: op = (r < 45) ? OP_PUSH : (r < 65) ? OP_POP :
                      (r < 94) ? OP_REMOVE : OP_CLEAR;
      endcase
      r = $urandom_range(0, 99);
      if (mode == 3) prio = 16'($signed($urandom_range(0, 4)) - 2);
      else if (r < 8) prio = -16'sd32768;
      else if (r < 16) prio = 16'sh7fff;
      else prio = 16'($urandom());
      data = $urandom();
      r = $urandom_range(0, 9);
      if (shadow_count > 0 && r < 8) pos = $urandom_range(0, shadow_count - 1);
      else if (r == 8) pos = shadow_count;
      else pos = $urandom_range(0, 255);
      // a share of pure noise: any operation with arbitrary fields
      if ($urandom_range(0, 9) == 0) begin
        op  = op_t'($urandom_range(0, 3));
        pos = $urandom_range(0, 255);
      end
      issue_op(op, prio, data, 8'(pos), 0, none_rpt);
    end

    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d operations: push %0d, pop %0d, remove %0d, clear %0d; peak %0d entries",
             ops_sent[0] + ops_sent[1] + ops_sent[2] + ops_sent[3], ops_sent[OP_PUSH],
             ops_sent[OP_POP], ops_sent[OP_REMOVE], ops_sent[OP_CLEAR], peak_count);
    $display("%0d result beats: ok %0d, full %0d, empty %0d, out of range %0d",
             reports_seen, status_seen[ST_OK], status_seen[ST_FULL],
             status_seen[ST_EMPTY], status_seen[ST_RANGE]);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
